### design/szm_pkg.sv
// shared types and constants for the stick calibrate zone mapper
// used by szm_datapath, szm_ctrl and stick_calibrate_zone_mapper
`timescale 1ns / 1ps
`default_nettype none
package szm_pkg;

  localparam int unsigned NumZones  = 6;
  localparam int unsigned FracBits  = 10;
  localparam int unsigned CoordBits = 8;
  localparam int unsigned FieldBits = FracBits + 1;
  localparam int unsigned RectBits  = 4 * FieldBits;
  localparam int unsigned DvdBits   = CoordBits + FracBits;
  localparam int unsigned DenBits   = CoordBits + 1;
  localparam int unsigned CntBits   = $clog2(DvdBits + 1);

  localparam logic [2:0] MODE_KEYS       = 3'd0;
  localparam logic [2:0] MODE_ABSOLUTE   = 3'd1;
  localparam logic [2:0] MODE_RELATIVE   = 3'd2;
  localparam logic [2:0] MODE_CAL_CENTER = 3'd3;
  localparam logic [2:0] MODE_CAL_BOUNDS = 3'd4;
  localparam logic [2:0] MODE_CAL_NORTH  = 3'd5;
  localparam logic [2:0] MODE_SPARE      = 3'd7;

  localparam logic [2:0] REG_MODE = 3'd0;
  localparam logic [2:0] REG_MASK = 3'd1;
  localparam logic [2:0] REG_RECT0 = 3'd2;

  localparam logic [1:0] EV_ABS_X   = 2'd0;
  localparam logic [1:0] EV_ABS_Y   = 2'd1;
  localparam logic [1:0] EV_PRESS   = 2'd2;
  localparam logic [1:0] EV_RELEASE = 2'd3;

  localparam logic [RectBits-1:0] RECT_RESET [NumZones] = '{
    44'd2641405095936, 44'd7924216129536, 44'd8796952854528,
    44'd8800387990323, 44'd880468295680,  44'd8800389877760
  };

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_start_x;
    logic div_start_y;
    logic compare;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] mode;
    logic       div_done;
    logic       pend_any;
    logic       pend_last;
    logic       slot_free;
  } sts_t;

endpackage
`default_nettype wire

### design/szm_datapath.sv
// datapath: config registers, calibration state, shared divider, zone compare
// and output register; depends on szm_pkg
`timescale 1ns / 1ps
`default_nettype none
module szm_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire szm_pkg::cmd_t                  cmd_i,
  output szm_pkg::sts_t                       sts_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [2:0]                     cfg_index_i,
  input  wire logic [szm_pkg::RectBits-1:0]   cfg_data_i,
  input  wire logic [szm_pkg::CoordBits-1:0]  sample_x_i,
  input  wire logic [szm_pkg::CoordBits-1:0]  sample_y_i,
  input  wire logic                           out_stall_i,
  output logic                                out_valid_o,
  output logic [1:0]                          event_kind_o,
  output logic [2:0]                          zone_index_o,
  output logic [7:0]                          event_value_o,
  output logic                                last_event_o
);
  localparam int unsigned CB = szm_pkg::CoordBits;
  localparam int unsigned FB = szm_pkg::FieldBits;
  localparam int unsigned NZ = szm_pkg::NumZones;
  localparam int unsigned DV = szm_pkg::DvdBits;
  localparam int unsigned DN = szm_pkg::DenBits;
  localparam logic [FB-1:0] ONE  = FB'(1) << szm_pkg::FracBits;
  localparam logic [FB-1:0] HALF = FB'(1) << (szm_pkg::FracBits - 1);
  localparam logic [CB-1:0] CMAX = '1;
  localparam logic [CB-1:0] CMID = CMAX >> 1;

  logic [2:0]                 mode_q;
  logic [NZ-1:0]              mask_q;
  logic [szm_pkg::RectBits-1:0] rect_q [NZ];
  logic [CB-1:0] cx_q, cy_q, minx_q, miny_q, maxx_q, maxy_q;
  logic [CB-1:0] sx_q, sy_q;
  logic [NZ-1:0] active_q, pend_q, press_q;
  logic          abs_q;
  logic [FB-1:0] dx_q, dy_q;

  // config and calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= szm_pkg::MODE_KEYS;
      mask_q <= '1;
      for (int i = 0; i < NZ; i++) rect_q[i] <= szm_pkg::RECT_RESET[i];
      cx_q   <= CMID;
      cy_q   <= CMID;
      minx_q <= '0;
      miny_q <= '0;
      maxx_q <= CMAX;
      maxy_q <= CMAX;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == szm_pkg::REG_MODE) begin
          if (cfg_data_i[2:0] != mode_q) begin
            mode_q <= cfg_data_i[2:0];
            if (cfg_data_i[2:0] == szm_pkg::MODE_CAL_BOUNDS) begin
              minx_q <= CMAX;
              miny_q <= CMAX;
              maxx_q <= '0;
              maxy_q <= '0;
            end
          end
        end else if (cfg_index_i == szm_pkg::REG_MASK) begin
          mask_q <= cfg_data_i[NZ-1:0];
        end else begin
          for (int i = 0; i < NZ; i++) begin
            if (cfg_index_i == szm_pkg::REG_RECT0 + 3'(i)) rect_q[i] <= cfg_data_i;
          end
        end
      end
      if (cmd_i.accept) begin
        if (mode_q == szm_pkg::MODE_CAL_CENTER) begin
          cx_q <= sample_x_i;
          cy_q <= sample_y_i;
        end
        if (mode_q == szm_pkg::MODE_CAL_BOUNDS) begin
          if (sample_x_i < minx_q) minx_q <= sample_x_i;
          if (sample_y_i < miny_q) miny_q <= sample_y_i;
          if (sample_x_i > maxx_q) maxx_q <= sample_x_i;
          if (sample_y_i > maxy_q) maxy_q <= sample_y_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sx_q <= sample_x_i;
      sy_q <= sample_y_i;
    end
  end

  // divider setup for the selected axis; the x divide starts in the accept cycle
  logic [CB-1:0] p, lo, c, hi;
  logic signed [CB:0] n_s, d_s;
  logic [CB-1:0] n_mag, d_mag;
  logic le;
  always_comb begin
    p  = cmd_i.div_start_y ? sy_q   : sample_x_i;
    lo = cmd_i.div_start_y ? miny_q : minx_q;
    c  = cmd_i.div_start_y ? cy_q   : cx_q;
    hi = cmd_i.div_start_y ? maxy_q : maxx_q;
    le = (p <= c);
    if (le) begin
      n_s = $signed({1'b0, p}) - $signed({1'b0, lo});
      d_s = $signed({1'b0, c}) - $signed({1'b0, lo});
    end else begin
      n_s = $signed({1'b0, hi}) - $signed({1'b0, p});
      d_s = $signed({1'b0, hi}) - $signed({1'b0, c});
    end
    n_mag = n_s[CB] ? CB'(-n_s) : n_s[CB-1:0];
    d_mag = d_s[CB] ? CB'(-d_s) : d_s[CB-1:0];
  end

  // restoring divider, one quotient bit a cycle
  logic [DN-1:0] den_q, rem_q;
  logic [DV-1:0] dq_q;
  logic [szm_pkg::CntBits-1:0] cnt_q;
  logic busy_q, le_q, neg_q, zero_q, axis_q;
  logic [DN:0] trial;
  logic [DN:0] diff;

  always_comb begin
    trial = {rem_q, dq_q[DV-1]};
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.div_start_x || cmd_i.div_start_y) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == szm_pkg::CntBits'(DV - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start_x || cmd_i.div_start_y) begin
      den_q  <= {d_mag, 1'b0};
      rem_q  <= '0;
      dq_q   <= {n_mag, {szm_pkg::FracBits{1'b0}}};
      le_q   <= le;
      neg_q  <= n_s[CB] ^ d_s[CB];
      zero_q <= (d_s == '0);
      axis_q <= cmd_i.div_start_y;
    end else if (busy_q) begin
      if (!diff[DN]) begin
        rem_q <= diff[DN-1:0];
        dq_q  <= {dq_q[DV-2:0], 1'b1};
      end else begin
        rem_q <= trial[DN-1:0];
        dq_q  <= {dq_q[DV-2:0], 1'b0};
      end
    end
  end

  logic div_done;
  assign div_done = busy_q && (cnt_q == szm_pkg::CntBits'(DV - 1));

  // quotient after the last step, then clamp
  logic [DV-1:0] q_fin;
  logic          over;
  logic [FB-1:0] axis_val;
  always_comb begin
    q_fin = {dq_q[DV-2:0], ~diff[DN]};
    over  = (q_fin > DV'(ONE));
    if (zero_q) axis_val = HALF;
    else if (le_q) axis_val = neg_q ? '0 : (over ? ONE : q_fin[FB-1:0]);
    else axis_val = neg_q ? ONE : (over ? '0 : ONE - q_fin[FB-1:0]);
  end

  always_ff @(posedge clk_i) begin
    if (div_done && !axis_q) dx_q <= axis_val;
    if (div_done &&  axis_q) dy_q <= axis_val;
  end

  // zone compare
  logic [NZ-1:0] hit;
  always_comb begin
    for (int i = 0; i < NZ; i++) begin
      hit[i] = (rect_q[i][FB-1:0] <= dx_q) && (dx_q <= rect_q[i][3*FB-1:2*FB]) &&
               (rect_q[i][2*FB-1:FB] <= dy_q) && (dy_q <= rect_q[i][4*FB-1:3*FB]);
    end
  end

  // lowest pending event
  logic [NZ-1:0] pick;
  logic [2:0]    pick_idx;
  logic          found;
  always_comb begin
    pick     = '0;
    pick_idx = '0;
    found    = 1'b0;
    for (int i = 0; i < NZ; i++) begin
      if (pend_q[i] && !found) begin
        pick[i]  = 1'b1;
        pick_idx = 3'(i);
        found    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      pend_q   <= '0;
      abs_q    <= 1'b0;
    end else begin
      if (cmd_i.accept && mode_q == szm_pkg::MODE_ABSOLUTE) begin
        pend_q <= NZ'(2'b11);
        abs_q  <= 1'b1;
      end else if (cmd_i.compare) begin
        pend_q   <= mask_q & (hit | active_q);
        abs_q    <= 1'b0;
        active_q <= (mask_q & hit) | (~mask_q & active_q);
      end else if (cmd_i.emit) begin
        pend_q <= pend_q & ~pick;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) press_q <= hit;
  end

  // output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.emit) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      last_event_o <= ((pend_q & ~pick) == '0);
      if (abs_q) begin
        event_kind_o  <= pick_idx[0] ? szm_pkg::EV_ABS_Y : szm_pkg::EV_ABS_X;
        zone_index_o  <= '0;
        event_value_o <= pick_idx[0] ? 8'(sy_q) : 8'(sx_q);
      end else begin
        event_kind_o  <= press_q[pick_idx] ? szm_pkg::EV_PRESS : szm_pkg::EV_RELEASE;
        zone_index_o  <= pick_idx;
        event_value_o <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.mode      = mode_q;
    sts_o.div_done  = div_done;
    sts_o.pend_any  = (pend_q != '0);
    sts_o.pend_last = ((pend_q & ~pick) == '0);
    sts_o.slot_free = !out_valid_q || !out_stall_i;
  end
endmodule
`default_nettype wire

### design/szm_ctrl.sv
// controller: sequences sample intake, the two divides, compare and emission
// depends on szm_pkg
`timescale 1ns / 1ps
`default_nettype none
module szm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire szm_pkg::sts_t sts_i,
  output szm_pkg::cmd_t      cmd_o
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DIVX = 5'b00010,
    S_DIVY = 5'b00100,
    S_CMP  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.mode == szm_pkg::MODE_KEYS) begin
            cmd_o.div_start_x = 1'b1;
            state_d = S_DIVX;
          end else if (sts_i.mode == szm_pkg::MODE_ABSOLUTE) begin
            state_d = S_EMIT;
          end
        end
      end
      S_DIVX: begin
        if (sts_i.div_done) begin
          cmd_o.div_start_y = 1'b1;
          state_d = S_DIVY;
        end
      end
      S_DIVY: begin
        if (sts_i.div_done) state_d = S_CMP;
      end
      S_CMP: begin
        cmd_o.compare = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!sts_i.pend_any) begin
          state_d = S_IDLE;
        end else if (sts_i.slot_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.pend_last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

### design/stick_calibrate_zone_mapper.sv
// top level of the stick calibrate zone mapper: controller plus datapath
// depends on szm_pkg, szm_ctrl and szm_datapath
`timescale 1ns / 1ps
`default_nettype none
// One sample is taken at a time. Calibration samples and samples in the silent
// modes finish in the cycle they are taken. An absolute sample gives two beats,
// one a cycle while the output is not stalled. A key-mode sample runs the shared
// restoring divider once per axis, then a compare step, then emits its press or
// release beats while the output is not stalled.
// The output register lets the next sample in while the final beat of the
// previous one still waits. Configuration writes are always ready and must be
// made only while the block is idle.
module stick_calibrate_zone_mapper (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [7:0]                    sample_x_i,
  input  wire logic [7:0]                    sample_y_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [1:0]                         event_kind_o,
  output logic [2:0]                         zone_index_o,
  output logic [7:0]                         event_value_o,
  output logic                               last_event_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [2:0]                    cfg_index_i,
  input  wire logic [szm_pkg::RectBits-1:0]  cfg_data_i
);
  szm_pkg::cmd_t cmd;
  szm_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  szm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  szm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .sample_x_i    (sample_x_i),
    .sample_y_i    (sample_y_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .event_kind_o  (event_kind_o),
    .zone_index_o  (zone_index_o),
    .event_value_o (event_value_o),
    .last_event_o  (last_event_o)
  );
endmodule
`default_nettype wire

### bench/testbench.sv
// self-checking bench for stick_calibrate_zone_mapper
// depends on szm_pkg and the design sources; predicts events and checks each out beat
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] zone;
    logic [7:0] value;
    logic       last;
  } stick_event_t;

  class event_scoreboard;
    logic [2:0]                   mode;
    logic [5:0]                   enable_mask;
    logic [szm_pkg::RectBits-1:0] rect [szm_pkg::NumZones];
    logic [7:0]                   cen_x, cen_y, lo_x, lo_y, hi_x, hi_y;
    bit                           active [szm_pkg::NumZones];
    stick_event_t                 pending [$];
    int                           errors;

    function new();
      mode = szm_pkg::MODE_KEYS;
      enable_mask = 6'h3f;
      for (int i = 0; i < szm_pkg::NumZones; i++) begin
        rect[i] = szm_pkg::RECT_RESET[i];
        active[i] = 0;
      end
      cen_x = 8'd127; cen_y = 8'd127;
      lo_x = 8'd0; lo_y = 8'd0; hi_x = 8'd255; hi_y = 8'd255;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [szm_pkg::RectBits-1:0] data);
      if (idx == szm_pkg::REG_MODE) begin
        if (data[2:0] != mode) begin
          mode = data[2:0];
          if (mode == szm_pkg::MODE_CAL_BOUNDS) begin
            lo_x = 8'd255; lo_y = 8'd255; hi_x = 8'd0; hi_y = 8'd0;
          end
        end
      end else if (idx == szm_pkg::REG_MASK) begin
        enable_mask = data[5:0];
      end else if (idx >= szm_pkg::REG_RECT0 && idx < szm_pkg::REG_RECT0 + szm_pkg::NumZones) begin
        rect[idx - szm_pkg::REG_RECT0] = data;
      end
    endfunction

    function int unsigned axis_fraction(int p, int lo, int c, int hi);
      longint num, den, r;
      if (p <= c) begin
        num = p - lo;
        den = 2 * (c - lo);
        if (den == 0) return 512;
        r = (num * 1024) / den;
      end else begin
        num = hi - p;
        den = 2 * (hi - c);
        if (den == 0) return 512;
        r = 1024 - (num * 1024) / den;
      end
      if (r < 0) r = 0;
      if (r > 1024) r = 1024;
      return 32'(r);
    endfunction

    function void note_sample(logic [7:0] x, logic [7:0] y);
      int unsigned dx, dy;
      int n;
      bit in_zone;
      logic [szm_pkg::FieldBits-1:0] f [4];
      n = pending.size();
      case (mode)
        szm_pkg::MODE_CAL_CENTER: begin
          cen_x = x; cen_y = y;
        end
        szm_pkg::MODE_CAL_BOUNDS: begin
          if (x < lo_x) lo_x = x;
          if (y < lo_y) lo_y = y;
          if (x > hi_x) hi_x = x;
          if (y > hi_y) hi_y = y;
        end
        szm_pkg::MODE_ABSOLUTE: begin
          pending.push_back('{szm_pkg::EV_ABS_X, 3'd0, x, 1'b0});
          pending.push_back('{szm_pkg::EV_ABS_Y, 3'd0, y, 1'b0});
        end
        szm_pkg::MODE_KEYS: begin
          dx = axis_fraction(x, lo_x, cen_x, hi_x);
          dy = axis_fraction(y, lo_y, cen_y, hi_y);
          for (int i = 0; i < szm_pkg::NumZones; i++) begin
            if (enable_mask[i]) begin
              for (int k = 0; k < 4; k++)
                f[k] = rect[i][k*szm_pkg::FieldBits +: szm_pkg::FieldBits];
              in_zone = f[0] <= dx && dx <= f[2] && f[1] <= dy && dy <= f[3];
              if (in_zone)
                pending.push_back('{szm_pkg::EV_PRESS, 3'(i), 8'd0, 1'b0});
              else if (active[i])
                pending.push_back('{szm_pkg::EV_RELEASE, 3'(i), 8'd0, 1'b0});
              active[i] = in_zone;
            end
          end
        end
        default: ;
      endcase
      if (pending.size() > n) pending[pending.size() - 1].last = 1'b1;
    endfunction

    function void check_event(stick_event_t got);
      stick_event_t exp_ev;
      if (pending.size() == 0) begin
        $error("unexpected beat kind=%0d zone=%0d", got.kind, got.zone);
        errors++;
        return;
      end
      exp_ev = pending.pop_front();
      if (got.kind != exp_ev.kind) begin
        $error("event_kind exp %0d got %0d", exp_ev.kind, got.kind); errors++;
      end
      if (got.zone != exp_ev.zone) begin
        $error("zone_index exp %0d got %0d", exp_ev.zone, got.zone); errors++;
      end
      if (got.value != exp_ev.value) begin
        $error("event_value exp %0d got %0d", exp_ev.value, got.value); errors++;
      end
      if (got.last != exp_ev.last) begin
        $error("last_event exp %0d got %0d", exp_ev.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, out_stall_i = 1'b0, cfg_valid_i = 0;
  logic [7:0] sample_x_i = 0, sample_y_i = 0;
  logic [2:0] cfg_index_i = 0;
  logic [szm_pkg::RectBits-1:0] cfg_data_i = 0;
  logic in_stall_o, out_valid_o, last_event_o, cfg_ready_o;
  logic [1:0] event_kind_o;
  logic [2:0] zone_index_o;
  logic [7:0] event_value_o;

  event_scoreboard board = new();
  int send_idle_pct = 0, stall_pct = 0;
  bit hold_off = 0;
  longint cycle_count = 0;

  always #1 clk_i = ~clk_i;

  stick_calibrate_zone_mapper dut (.*);

  // output side: random stall, plus a long hold-off when asked
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_event('{event_kind_o, zone_index_o, event_value_o, last_event_o});
    out_stall_i <= hold_off || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 3_000_000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // valid stays high after the accepting edge until the next call or a drain
  task automatic send_sample(logic [7:0] x, logic [7:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1; sample_x_i <= x; sample_y_i <= y;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_sample(x, y);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [szm_pkg::RectBits-1:0] data);
    drain();
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
    board.write_reg(idx, data);
  endtask

  function automatic logic [szm_pkg::RectBits-1:0] make_rect(int x1, int y1, int x2, int y2);
    return {11'(y2), 11'(x2), 11'(y1), 11'(x1)};
  endfunction

  // calibrate with a few samples, then run key-mode traffic
  task automatic calibrate_run(int n);
    write_reg(szm_pkg::REG_MODE, szm_pkg::MODE_CAL_BOUNDS);
    repeat (1 + $urandom_range(4)) send_sample(8'($urandom), 8'($urandom));
    write_reg(szm_pkg::REG_MODE, szm_pkg::MODE_CAL_CENTER);
    send_sample(8'($urandom), 8'($urandom));
    write_reg(szm_pkg::REG_MODE, szm_pkg::MODE_KEYS);
    repeat (n) send_sample(8'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: reset settings, extremes and center
    send_sample(0, 0); send_sample(255, 255); send_sample(127, 127);
    send_sample(128, 0); send_sample(0, 255); send_sample(127, 128);
    write_reg(szm_pkg::REG_MODE, szm_pkg::MODE_ABSOLUTE);
    send_sample(8'haa, 8'h55); send_sample(8'h55, 8'haa);
    write_reg(szm_pkg::REG_MODE, szm_pkg::MODE_RELATIVE); send_sample(1, 2);
    write_reg(szm_pkg::REG_MODE, szm_pkg::MODE_CAL_NORTH); send_sample(3, 4);
    write_reg(szm_pkg::REG_MODE, szm_pkg::MODE_SPARE); send_sample(5, 6);
    // bounds mode with no samples: inverted bounds, zero divisor on both axes above the center
    write_reg(szm_pkg::REG_MODE, szm_pkg::MODE_CAL_BOUNDS);
    write_reg(szm_pkg::REG_MODE, szm_pkg::MODE_CAL_CENTER);
    send_sample(0, 0);
    write_reg(szm_pkg::REG_MODE, szm_pkg::MODE_KEYS);
    send_sample(0, 0); send_sample(200, 200);
    // rewriting the same mode leaves the box alone
    write_reg(szm_pkg::REG_MODE, szm_pkg::MODE_KEYS);
    write_reg(szm_pkg::REG_MASK, 0); send_sample(10, 10);
    write_reg(szm_pkg::REG_MASK, 6'h3f);
    for (int z = 0; z < szm_pkg::NumZones; z++)
      write_reg(3'(szm_pkg::REG_RECT0 + z), make_rect(0, 0, 2047, 2047));
    send_sample(90, 200); send_sample(255, 0);
    for (int z = 0; z < szm_pkg::NumZones; z++) write_reg(3'(szm_pkg::REG_RECT0 + z), 0);
    send_sample(0, 0); send_sample(100, 100);
    for (int z = 0; z < szm_pkg::NumZones; z++)
      write_reg(3'(szm_pkg::REG_RECT0 + z), szm_pkg::RECT_RESET[z]);

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      if (ph == 4) begin
        write_reg(szm_pkg::REG_MASK, szm_pkg::RectBits'($urandom_range(63)));
        for (int z = 0; z < szm_pkg::NumZones; z++)
          write_reg(3'(szm_pkg::REG_RECT0 + z),
                    make_rect($urandom_range(1100), $urandom_range(1100),
                              $urandom_range(2047), $urandom_range(2047)));
      end
      if (ph == 6)
        write_reg(3'(szm_pkg::REG_RECT0 + $urandom_range(5)), {szm_pkg::RectBits{1'b1}});
      if (ph == 7) begin
        write_reg(szm_pkg::REG_MASK, 6'h3f);
        for (int z = 0; z < szm_pkg::NumZones; z++)
          write_reg(3'(szm_pkg::REG_RECT0 + z), szm_pkg::RECT_RESET[z]);
      end
      calibrate_run(35);
      write_reg(szm_pkg::REG_MODE, szm_pkg::MODE_ABSOLUTE);
      repeat (10) send_sample(8'($urandom), 8'($urandom));
      if (ph == 2) begin
        // long receiver hold-off while samples keep coming
        fork
          begin hold_off = 1; repeat (400) @(posedge clk_i); hold_off = 0; end
          repeat (8) send_sample(8'($urandom), 8'($urandom));
        join
        drain();
      end
    end

    drain();
    if (board.errors == 0 && board.pending.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
